// ===== rtl/dsv_pkg.sv =====
// Shared types, constants and helper functions for the date-time string validator.
// Used by dsv_parser, dsv_checker and datetime_string_validator; depends on nothing.
`default_nettype none

package dsv_pkg;

	localparam logic [3:0]  STR_LEN        = 4'd14;
	localparam logic [3:0]  POS_SAT        = 4'd15;
	localparam logic [13:0] MIN_YEAR_RESET = 14'd1970;

	// Character positions where each decimal field ends (exclusive).
	localparam logic [3:0] CENT_END   = 4'd2;
	localparam logic [3:0] YEAR_END   = 4'd4;
	localparam logic [3:0] MONTH_END  = 4'd6;
	localparam logic [3:0] DAY_END    = 4'd8;
	localparam logic [3:0] HOUR_END   = 4'd10;
	localparam logic [3:0] MINUTE_END = 4'd12;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [6:0] MONTH_FEB  = 7'd2;
	localparam logic [6:0] MONTH_DEC  = 7'd12;
	localparam logic [6:0] HOUR_MAX   = 7'd23;
	localparam logic [6:0] MINSEC_MAX = 7'd59;

	localparam logic STATUS_VALID   = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	// Snapshot of the accumulators for one finished string.
	typedef struct packed {
		logic [3:0]  pos;
		logic        bad;
		logic [13:0] year;
		logic [6:0]  cent;
		logic [6:0]  yy;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} parsed_t;

	// v * 10 + d, built from two shifts and adds.
	function automatic logic [13:0] times10_add(input logic [13:0] v, input logic [3:0] d);
		logic [13:0] r;
		r = (v << 3) + (v << 1) + {10'd0, d};
		return r;
	endfunction

	function automatic logic [4:0] month_days(input logic [6:0] month, input logic leap);
		logic [4:0] r;
		case (month)
			7'd1:    r = 5'd31;
			7'd2:    r = leap ? 5'd29 : 5'd28;
			7'd3:    r = 5'd31;
			7'd4:    r = 5'd30;
			7'd5:    r = 5'd31;
			7'd6:    r = 5'd30;
			7'd7:    r = 5'd31;
			7'd8:    r = 5'd31;
			7'd9:    r = 5'd30;
			7'd10:   r = 5'd31;
			7'd11:   r = 5'd30;
			7'd12:   r = 5'd31;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dsv_parser.sv =====
// Character accumulator for the date-time validator: position count, non-digit flag and
// decimal field accumulators, plus the snapshot register handed to the checker. Uses dsv_pkg.
`default_nettype none

module dsv_parser (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   accept,
	input  wire  [7:0]            char_code,
	input  wire                   last_char,
	input  wire                   take_s1,
	output logic                  valid_s1,
	output dsv_pkg::parsed_t      parsed_s1
);
	import dsv_pkg::*;

	parsed_t acc_q;
	parsed_t acc_next;
	logic    is_digit;
	logic [3:0] dg;

	assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign dg       = char_code[3:0];

	always_comb begin
		acc_next = acc_q;
		if (acc_q.pos < STR_LEN) begin
			if (!is_digit) begin
				acc_next.bad = 1'b1;
			end else if (acc_q.pos < YEAR_END) begin
				acc_next.year = times10_add(acc_q.year, dg);
				// Century and the last two digits are kept apart for the leap test.
				if (acc_q.pos < CENT_END) begin
					acc_next.cent = 7'(times10_add({7'd0, acc_q.cent}, dg));
				end else begin
					acc_next.yy = 7'(times10_add({7'd0, acc_q.yy}, dg));
				end
			end else if (acc_q.pos < MONTH_END) begin
				acc_next.month = 7'(times10_add({7'd0, acc_q.month}, dg));
			end else if (acc_q.pos < DAY_END) begin
				acc_next.day = 7'(times10_add({7'd0, acc_q.day}, dg));
			end else if (acc_q.pos < HOUR_END) begin
				acc_next.hour = 7'(times10_add({7'd0, acc_q.hour}, dg));
			end else if (acc_q.pos < MINUTE_END) begin
				acc_next.minute = 7'(times10_add({7'd0, acc_q.minute}, dg));
			end else begin
				acc_next.second = 7'(times10_add({7'd0, acc_q.second}, dg));
			end
		end
		if (acc_q.pos != POS_SAT) begin
			acc_next.pos = acc_q.pos + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (last_char) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_next;
				end
			end
			if (accept && last_char) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_char) begin
			parsed_s1 <= acc_next;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_char) |=> (acc_q.pos == 4'd0 && !acc_q.bad && acc_q.year == 14'd0))
		else $error("accumulators not cleared after the last word");

	a_pos_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !last_char && acc_q.pos != POS_SAT) |=> (acc_q.pos == $past(acc_q.pos) + 4'd1))
		else $error("position count did not advance");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !last_char && acc_q.pos == POS_SAT) |=> (acc_q.pos == POS_SAT))
		else $error("position count left saturation");

endmodule

`default_nettype wire

// ===== rtl/dsv_checker.sv =====
// Range and calendar checks on a finished string, and the result register of the stream.
// Uses dsv_pkg.
`default_nettype none

module dsv_checker (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   valid_s1,
	input  wire dsv_pkg::parsed_t parsed_s1,
	input  wire  [13:0]           min_year,
	input  wire                   m_tready,
	output logic                  take_s1,
	output logic                  m_tvalid,
	output logic                  status_s2,
	output logic [13:0]           year_s2,
	output logic [6:0]            month_s2,
	output logic [6:0]            day_s2,
	output logic [6:0]            hour_s2,
	output logic [6:0]            minute_s2,
	output logic [6:0]            second_s2
);
	import dsv_pkg::*;

	logic       leap;
	logic [4:0] mlen;
	logic       ok;

	// A year is a leap year when its last two digits divide by four, or when they are
	// zero and the century divides by four.
	assign leap = (parsed_s1.yy == 7'd0) ? (parsed_s1.cent[1:0] == 2'd0)
	                                     : (parsed_s1.yy[1:0] == 2'd0);
	assign mlen = month_days(parsed_s1.month, leap);

	assign ok = (parsed_s1.pos == STR_LEN) && !parsed_s1.bad &&
	            (parsed_s1.year >= min_year) &&
	            (parsed_s1.month >= 7'd1) && (parsed_s1.month <= MONTH_DEC) &&
	            (parsed_s1.day >= 7'd1) && (parsed_s1.day <= {2'b00, mlen}) &&
	            (parsed_s1.hour <= HOUR_MAX) && (parsed_s1.minute <= MINSEC_MAX) &&
	            (parsed_s1.second <= MINSEC_MAX);

	assign take_s1 = valid_s1 && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			status_s2 <= ok ? STATUS_VALID : STATUS_INVALID;
			year_s2   <= ok ? parsed_s1.year : 14'd0;
			month_s2  <= ok ? parsed_s1.month : 7'd0;
			day_s2    <= ok ? parsed_s1.day : 7'd0;
			hour_s2   <= ok ? parsed_s1.hour : 7'd0;
			minute_s2 <= ok ? parsed_s1.minute : 7'd0;
			second_s2 <= ok ? parsed_s1.second : 7'd0;
		end
	end

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_s2 == STATUS_INVALID) |->
		(year_s2 == 14'd0 && month_s2 == 7'd0 && day_s2 == 7'd0 && hour_s2 == 7'd0 &&
		 minute_s2 == 7'd0 && second_s2 == 7'd0))
		else $error("invalid result carries nonzero fields");

	a_valid_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_s2 == STATUS_VALID) |->
		(month_s2 >= 7'd1 && month_s2 <= MONTH_DEC && day_s2 >= 7'd1 && day_s2 <= 7'd31 &&
		 hour_s2 <= HOUR_MAX && minute_s2 <= MINSEC_MAX && second_s2 <= MINSEC_MAX))
		else $error("valid result out of range");

	a_feb_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_s2 == STATUS_VALID && month_s2 == MONTH_FEB) |-> (day_s2 <= 7'd29))
		else $error("February day beyond 29 passed");

endmodule

`default_nettype wire

// ===== rtl/datetime_string_validator.sv =====
// Top level of the yyyyMMddHHmmss date-time string validator.
// Depends on dsv_pkg, dsv_parser and dsv_checker.
//
// Usage:
//   The slave stream takes one ASCII character per word on s_tdata; s_tlast marks the
//   final character of a string. For every string the master stream gives one word:
//   m_tuser is 0 for a valid date-time and 1 for an invalid string, and m_tdata holds
//   the parsed year, month, day, hour, minute and second (all zero when invalid).
//   The cfg channel writes the minimum accepted year; cfg_ready is always high, and it
//   should be written only while no string is in flight.
//   Throughput: one character per cycle while s_tready is high. The result for a string
//   moves from the snapshot register through the check logic into the result register,
//   which drives the master side.
//   When the receiver stalls, the result register holds its word and one more finished
//   string can wait in the snapshot register; while that register is full and cannot
//   move on, s_tready is low for every character.
//   Reset clears all accumulators and both valid flags, and sets the minimum year to 1970.
`default_nettype none

module datetime_string_validator (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] char_code
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // [13:0] year, [20:14] month, [27:21] day,
	                               // [34:28] hour, [41:35] minute, [48:42] second, rest zero
	output logic        m_tuser,   // [0] status
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [13:0] cfg_data
);
	import dsv_pkg::*;

	logic        accept;
	logic        valid_s1;
	logic        take_s1;
	parsed_t     parsed_s1;
	logic [13:0] min_year_q;
	logic [13:0] year_s2;
	logic [6:0]  month_s2;
	logic [6:0]  day_s2;
	logic [6:0]  hour_s2;
	logic [6:0]  minute_s2;
	logic [6:0]  second_s2;

	assign cfg_ready = 1'b1;
	assign s_tready  = !valid_s1 || take_s1;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_year_q <= cfg_data;
		end
	end

	dsv_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (s_tdata),
		.last_char (s_tlast),
		.take_s1   (take_s1),
		.valid_s1  (valid_s1),
		.parsed_s1 (parsed_s1)
	);

	dsv_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.parsed_s1 (parsed_s1),
		.min_year  (min_year_q),
		.m_tready  (m_tready),
		.take_s1   (take_s1),
		.m_tvalid  (m_tvalid),
		.status_s2 (m_tuser),
		.year_s2   (year_s2),
		.month_s2  (month_s2),
		.day_s2    (day_s2),
		.hour_s2   (hour_s2),
		.minute_s2 (minute_s2),
		.second_s2 (second_s2)
	);

	assign m_tdata = {7'd0, second_s2, minute_s2, hour_s2, day_s2, month_s2, year_s2};

endmodule

`default_nettype wire

// ===== dv/datetime_string_validator_tb.sv =====
// Self-checking testbench for datetime_string_validator: drives character strings on the
// slave stream, predicts each result word and compares it on the master stream.
// Depends on dsv_pkg and the validator RTL.
`timescale 1ns / 100ps

module testbench;
	import dsv_pkg::*;

	localparam int IDLE_LIMIT      = 1000;
	localparam int CHARS_PER_PHASE = 320;
	localparam int SETTLE_CYCLES   = 6;
	localparam int PHASES          = 6;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [13:0] cfg_data;

	typedef struct {
		logic        status;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} date_result_t;

	class datetime_scoreboard;
		logic [13:0]  min_year;
		logic [3:0]   position;
		logic         bad_char;
		logic [13:0]  year_acc;
		logic [6:0]   month_acc;
		logic [6:0]   day_acc;
		logic [6:0]   hour_acc;
		logic [6:0]   minute_acc;
		logic [6:0]   second_acc;
		date_result_t expected_dates[$];
		int           mismatches;
		int           checked;
		int           valid_count;

		function new();
			min_year    = MIN_YEAR_RESET;
			mismatches  = 0;
			checked     = 0;
			valid_count = 0;
			clear();
		endfunction

		function void clear();
			position   = '0;
			bad_char   = 1'b0;
			year_acc   = '0;
			month_acc  = '0;
			day_acc    = '0;
			hour_acc   = '0;
			minute_acc = '0;
			second_acc = '0;
		endfunction

		function void set_min_year(logic [13:0] value);
			min_year = value;
		endfunction

		function int month_length(int month, int year);
			bit leap;
			leap = (year % 400 == 0) || (year % 100 != 0 && year % 4 == 0);
			case (month)
				2:                    return leap ? 29 : 28;
				4, 6, 9, 11:          return 30;
				1, 3, 5, 7, 8, 10, 12: return 31;
				default:              return 0;
			endcase
		endfunction

		function int pending();
			return expected_dates.size();
		endfunction

		// Called once per accepted slave word; a last word queues one expected result.
		function void note_char(logic [7:0] c, logic last);
			date_result_t r;
			logic [3:0]   digit;
			bit           ok;
			if (position < STR_LEN) begin
				if (c < CHAR_ZERO || c > CHAR_NINE) begin
					bad_char = 1'b1;
				end else begin
					digit = 4'(c - CHAR_ZERO);
					if (position < YEAR_END)
						year_acc = 14'(year_acc * 10 + digit);
					else if (position < MONTH_END)
						month_acc = 7'(month_acc * 10 + digit);
					else if (position < DAY_END)
						day_acc = 7'(day_acc * 10 + digit);
					else if (position < HOUR_END)
						hour_acc = 7'(hour_acc * 10 + digit);
					else if (position < MINUTE_END)
						minute_acc = 7'(minute_acc * 10 + digit);
					else
						second_acc = 7'(second_acc * 10 + digit);
				end
			end
			if (position < POS_SAT)
				position = position + 4'd1;
			if (!last)
				return;

			// An unknown month gives a length of zero, so the day test fails too.
			ok = position == STR_LEN && !bad_char && year_acc >= min_year &&
			     day_acc >= 1 && day_acc <= month_length(month_acc, year_acc) &&
			     hour_acc <= HOUR_MAX && minute_acc <= MINSEC_MAX && second_acc <= MINSEC_MAX;
			r = '{default: '0};
			r.status = STATUS_INVALID;
			if (ok) begin
				r.status = STATUS_VALID;
				r.year   = year_acc;
				r.month  = month_acc;
				r.day    = day_acc;
				r.hour   = hour_acc;
				r.minute = minute_acc;
				r.second = second_acc;
			end
			expected_dates.push_back(r);
			clear();
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH %s", $time, msg);
			mismatches++;
		endtask

		task check_word(logic status, logic [55:0] data);
			date_result_t e;
			bit           differs;
			if (expected_dates.size() == 0) begin
				report($sformatf("result word with nothing expected: status %0b data %h",
					status, data));
				return;
			end
			e = expected_dates.pop_front();
			checked++;
			differs = status !== e.status || data[13:0] !== e.year ||
			          data[20:14] !== e.month || data[27:21] !== e.day ||
			          data[34:28] !== e.hour || data[41:35] !== e.minute ||
			          data[48:42] !== e.second || data[55:49] !== '0;
			if (differs)
				report($sformatf("result %0d: got %0b %0d-%0d-%0d %0d:%0d:%0d pad %h, %s",
					checked, status, data[13:0], data[20:14], data[27:21], data[34:28],
					data[41:35], data[48:42], data[55:49],
					$sformatf("want %0b %0d-%0d-%0d %0d:%0d:%0d", e.status, e.year,
						e.month, e.day, e.hour, e.minute, e.second)));
			else if (e.status == STATUS_VALID)
				valid_count++;
		endtask
	endclass

	datetime_scoreboard dates;
	logic [7:0]         text_q[$];
	int                 chars_sent   = 0;
	int                 strings_sent = 0;
	int                 cfg_writes   = 0;
	int                 idle_cycles  = 0;
	bit                 tx_burst     = 1'b0;
	bit                 rx_burst     = 1'b0;

	datetime_string_validator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),     // [7:0] char_code
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),     // [13:0] year, [20:14] month, [27:21] day,
		                          // [34:28] hour, [41:35] minute, [48:42] second
		.m_tuser   (m_tuser),     // [0] status
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Ends the run if no handshake of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] Watchdog: no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: a random stall before each result word, with stretches of none.
	initial begin
		int stall;
		int served;
		served = 0;
		m_tready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if (served % 24 == 0)
				rx_burst = ($urandom_range(0, 2) == 0);
			stall = rx_burst ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1) @(posedge clk);
			dates.check_word(m_tuser, m_tdata);
			served++;
		end
	end

	// Valid stays high from one word to the next when the gap is zero.
	task automatic send_char(logic [7:0] c, logic last, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		dates.note_char(c, last);
		chars_sent++;
	endtask

	task automatic send_text();
		int i;
		if (strings_sent % 16 == 0)
			tx_burst = ($urandom_range(0, 2) == 0);
		for (i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1, tx_burst ? 0 : $urandom_range(0, 15));
		strings_sent++;
	endtask

	// Writes are made only with no string in flight and the pipeline drained.
	task automatic write_min_year(logic [13:0] value);
		s_tvalid <= 1'b0;
		while (dates.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
		dates.set_min_year(value);
		cfg_writes++;
	endtask

	function automatic void load_text(string s);
		int i;
		text_q.delete();
		for (i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function automatic void push_digits(int value, int digits);
		int div;
		div = 1;
		repeat (digits - 1) div *= 10;
		while (div > 0) begin
			text_q.push_back(CHAR_ZERO + 8'((value / div) % 10));
			div /= 10;
		end
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
		return c;
	endfunction

	// Years cluster around the minimum and around the century leap rules.
	function automatic int pick_year();
		int y;
		case ($urandom_range(0, 3))
			0: y = int'(dates.min_year) + int'($urandom_range(0, 2)) - 1;
			1: begin
				case ($urandom_range(0, 5))
					0:       y = 1600;
					1:       y = 1900;
					2:       y = 2000;
					3:       y = 2100;
					4:       y = 2400;
					default: y = 4 * $urandom_range(0, 2499);
				endcase
			end
			2: y = $urandom_range(0, 9999);
			default: y = $urandom_range(int'(dates.min_year), 9999);
		endcase
		if (y < 0)
			y = 0;
		if (y > 9999)
			y = 9999;
		return y;
	endfunction

	// A well-formed 14-digit date-time, with one field pushed out of range a third of the time.
	function automatic void build_date();
		int y, m, d, h, mi, s, len;
		y  = pick_year();
		m  = $urandom_range(1, 12);
		d  = $urandom_range(1, dates.month_length(m, y));
		if ($urandom_range(0, 6) == 0) begin
			m = 2;
			d = 29;
		end
		len = dates.month_length(m, y);
		h  = $urandom_range(0, 23);
		mi = $urandom_range(0, 59);
		s  = $urandom_range(0, 59);
		case ($urandom_range(0, 14))
			0: m  = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
			1: d  = $urandom_range(0, 1) ? 0 : $urandom_range(len + 1, 99);
			2: h  = $urandom_range(24, 99);
			3: mi = $urandom_range(60, 99);
			4: s  = $urandom_range(60, 99);
			5: begin
				h  = 23;
				mi = 59;
				s  = 59;
			end
			default: ;
		endcase
		text_q.delete();
		push_digits(y, 4);
		push_digits(m, 2);
		push_digits(d, 2);
		push_digits(h, 2);
		push_digits(mi, 2);
		push_digits(s, 2);
	endfunction

	function automatic void build_random_text();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			build_date();
		end else if (kind < 67) begin
			build_date();
			text_q[$urandom_range(0, 13)] = non_digit();
		end else if (kind < 77) begin
			build_date();
			n = $urandom_range(1, 13);
			while (text_q.size() > n) text_q.delete(text_q.size() - 1);
		end else if (kind < 88) begin
			build_date();
			n = $urandom_range(1, 6);
			repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			text_q.delete();
			n = $urandom_range(1, 16);
			repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic logic [13:0] phase_min_year(int phase);
		case (phase)
			1:       return 14'd0;
			2:       return 14'd9999;
			3:       return 14'd2000;
			4:       return 14'($urandom_range(0, 9999));
			default: return MIN_YEAR_RESET;
		endcase
	endfunction

	initial begin
		int phase;
		int phase_start;
		int wait_cycles;
		dates = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings under the reset minimum year: a leap day in a year divisible
		// by 400 at the last second of the day, one-character strings at both ends of the
		// byte range, and a February 29 in a century that is not a leap year.
		load_text("20000229235959");
		send_text();
		text_q.delete();
		text_q.push_back(8'hFF);
		send_text();
		text_q.delete();
		text_q.push_back(8'h00);
		send_text();
		load_text("21000229000000");
		send_text();

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0)
				write_min_year(phase_min_year(phase));
			phase_start = chars_sent;
			while (chars_sent - phase_start < CHARS_PER_PHASE) begin
				build_random_text();
				send_text();
			end
		end
		s_tvalid <= 1'b0;

		wait_cycles = 0;
		while (dates.pending() != 0 && wait_cycles < IDLE_LIMIT / 2) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (dates.pending() != 0)
			dates.report($sformatf("%0d expected results never arrived", dates.pending()));

		$display("Sent %0d characters in %0d strings across %0d minimum-year writes.",
			chars_sent, strings_sent, cfg_writes);
		$display("Compared %0d result words; %0d were valid date-times.",
			dates.checked, dates.valid_count);
		if (dates.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
